// ----- rtl/sphere_triangle_overlap_test_core_macros.svh -----
// Assertion macros for the sphere/triangle overlap core.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef SPHERE_TRIANGLE_OVERLAP_TEST_CORE_MACROS_SVH
`define SPHERE_TRIANGLE_OVERLAP_TEST_CORE_MACROS_SVH

// same-cycle implication
`define STOC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/stoc_pkg.sv -----
// Shared types and constants for the sphere/triangle overlap core.
// No dependencies.
package stoc_pkg;

   localparam int COORD_WIDTH_DEF  = 16;
   localparam int WEIGHT_FRAC_DEF  = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int FRONT_STAGES     = 5;
   localparam int SEL_STAGES       = 1;
   localparam int TAIL_STAGES      = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      REG_V0  = 3'd0,
      REG_V1  = 3'd1,
      REG_E01 = 3'd2,
      REG_V2  = 3'd3,
      REG_E02 = 3'd4,
      REG_E12 = 3'd5,
      REG_INT = 3'd6
   } region_type;

endpackage

// ----- rtl/stoc_front.sv -----
// Front pipeline: edge/offset vectors, six dot products, and the three
// second-order terms va, vb, vc via split multiplies. Uses stoc_pkg.
module stoc_front import stoc_pkg::*; #(
   parameter  int CW   = COORD_WIDTH_DEF,
   localparam int DW   = CW + 1,
   localparam int DOTW = 2 * DW + 2,
   localparam int PW   = 2 * DOTW,
   localparam int VW   = PW + 1
) (
   input  logic                    clock,
   input  logic [FRONT_STAGES-1:0] en,
   input  logic signed [CW-1:0]    vtx [9],
   input  logic signed [CW-1:0]    ctr [3],
   output logic signed [CW-1:0]    vtx_out [9],
   output logic signed [DOTW-1:0]  dot_out [6],
   output logic signed [VW-1:0]    va,
   output logic signed [VW-1:0]    vb,
   output logic signed [VW-1:0]    vc
);

   localparam int SP   = DOTW / 2;
   localparam int LOW  = SP + 1 + DOTW;
   localparam int HIW  = 2 * DOTW - SP;
   localparam int XI [6] = '{0, 2, 4, 0, 2, 4};
   localparam int YI [6] = '{3, 1, 1, 5, 5, 3};

   logic signed [CW-1:0]   vtx_ff  [FRONT_STAGES][9];
   logic signed [DW-1:0]   side_in [2][3];
   logic signed [DW-1:0]   side_ff [2][3];
   logic signed [DW-1:0]   off_in  [3][3];
   logic signed [DW-1:0]   off_ff  [3][3];
   logic signed [DOTW-1:0] dot_in  [6];
   logic signed [DOTW-1:0] dot_ff  [1:FRONT_STAGES-1][6];
   logic signed [LOW-1:0]  plo_in  [6];
   logic signed [LOW-1:0]  plo_ff  [6];
   logic signed [HIW-1:0]  phi_in  [6];
   logic signed [HIW-1:0]  phi_ff  [6];
   logic signed [PW-1:0]   prod_in [6];
   logic signed [PW-1:0]   prod_ff [6];
   logic signed [VW-1:0]   va_ff, vb_ff, vc_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         side_in[0][k] = DW'(vtx[3 + k]) - DW'(vtx[k]);
         side_in[1][k] = DW'(vtx[6 + k]) - DW'(vtx[k]);
         for (int r = 0; r < 3; r++) begin
            off_in[r][k] = DW'(ctr[k]) - DW'(vtx[3 * r + k]);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         dot_in[j] = '0;
         for (int k = 0; k < 3; k++) begin
            dot_in[j] = dot_in[j] + DOTW'(side_ff[j & 1][k] * off_ff[j >> 1][k]);
         end
      end
   end

   // split multiply: x = hi * 2^SP + lo
   always_comb begin
      logic signed [SP:0]        lx;
      logic signed [DOTW-SP-1:0] hx;
      for (int m = 0; m < 6; m++) begin
         lx = {1'b0, dot_ff[1][XI[m]][SP-1:0]};
         hx = dot_ff[1][XI[m]][DOTW-1:SP];
         plo_in[m] = lx * dot_ff[1][YI[m]];
         phi_in[m] = hx * dot_ff[1][YI[m]];
      end
   end

   always_comb begin
      for (int m = 0; m < 6; m++) begin
         prod_in[m] = (PW'(phi_ff[m]) <<< SP) + PW'(plo_ff[m]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vtx_ff[0] <= vtx;
         side_ff   <= side_in;
         off_ff    <= off_in;
      end
      if (en[1]) begin
         vtx_ff[1] <= vtx_ff[0];
         dot_ff[1] <= dot_in;
      end
      if (en[2]) begin
         vtx_ff[2] <= vtx_ff[1];
         dot_ff[2] <= dot_ff[1];
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
      end
      if (en[3]) begin
         vtx_ff[3] <= vtx_ff[2];
         dot_ff[3] <= dot_ff[2];
         prod_ff   <= prod_in;
      end
      if (en[4]) begin
         vtx_ff[4] <= vtx_ff[3];
         dot_ff[4] <= dot_ff[3];
         vc_ff     <= VW'(prod_ff[0]) - VW'(prod_ff[1]);
         vb_ff     <= VW'(prod_ff[2]) - VW'(prod_ff[3]);
         va_ff     <= VW'(prod_ff[4]) - VW'(prod_ff[5]);
      end
   end

   assign vtx_out = vtx_ff[FRONT_STAGES-1];
   assign dot_out = dot_ff[FRONT_STAGES-1];
   assign va      = va_ff;
   assign vb      = vb_ff;
   assign vc      = vc_ff;

endmodule

// ----- rtl/stoc_sel.sv -----
// Region select: Voronoi tests, base point, blend directions and the
// weight numerators/denominator for the divider. Uses stoc_pkg.
module stoc_sel import stoc_pkg::*; #(
   parameter  int CW   = COORD_WIDTH_DEF,
   localparam int DW   = CW + 1,
   localparam int DOTW = 2 * DW + 2,
   localparam int VW   = 2 * DOTW + 1,
   localparam int NW   = VW + 2
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [CW-1:0]   vtx [9],
   input  logic signed [DOTW-1:0] dot [6],
   input  logic signed [VW-1:0]   va,
   input  logic signed [VW-1:0]   vb,
   input  logic signed [VW-1:0]   vc,
   output logic signed [CW-1:0]   base [3],
   output logic signed [DW-1:0]   dir_a [3],
   output logic signed [DW-1:0]   dir_b [3],
   output region_type             region,
   output logic signed [NW-1:0]   num_a,
   output logic signed [NW-1:0]   num_b,
   output logic signed [NW-1:0]   den
);

   logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;
   logic signed [DW-1:0]   e01 [3];
   logic signed [DW-1:0]   e02 [3];
   logic signed [DW-1:0]   e12 [3];
   logic signed [CW-1:0]   base_in [3];
   logic signed [DW-1:0]   dir_a_in [3];
   logic signed [DW-1:0]   dir_b_in [3];
   region_type             region_in;
   logic signed [NW-1:0]   num_a_in, num_b_in, den_in;
   logic signed [CW-1:0]   base_ff [3];
   logic signed [DW-1:0]   dir_a_ff [3];
   logic signed [DW-1:0]   dir_b_ff [3];
   region_type             region_ff;
   logic signed [NW-1:0]   num_a_ff, num_b_ff, den_ff;

   assign d1 = dot[0];
   assign d2 = dot[1];
   assign d3 = dot[2];
   assign d4 = dot[3];
   assign d5 = dot[4];
   assign d6 = dot[5];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e01[k]      = DW'(vtx[3 + k]) - DW'(vtx[k]);
         e02[k]      = DW'(vtx[6 + k]) - DW'(vtx[k]);
         e12[k]      = DW'(vtx[6 + k]) - DW'(vtx[3 + k]);
         base_in[k]  = vtx[k];
         dir_a_in[k] = '0;
         dir_b_in[k] = '0;
      end
      num_a_in  = '0;
      num_b_in  = '0;
      den_in    = NW'(1);
      region_in = REG_INT;
      if (d1 <= 0 && d2 <= 0) begin
         region_in = REG_V0;
      end else if (d3 >= 0 && d4 <= 0) begin
         region_in = REG_V1;
         for (int k = 0; k < 3; k++) base_in[k] = vtx[3 + k];
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
         region_in = REG_E01;
         dir_a_in  = e01;
         num_a_in  = NW'(d1);
         den_in    = NW'(d1) - NW'(d3);
      end else if (d6 >= 0 && d5 <= d6) begin
         region_in = REG_V2;
         for (int k = 0; k < 3; k++) base_in[k] = vtx[6 + k];
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
         region_in = REG_E02;
         dir_a_in  = e02;
         num_a_in  = NW'(d2);
         den_in    = NW'(d2) - NW'(d6);
      end else if (va <= 0 && d4 >= d3 && d5 >= d6) begin
         region_in = REG_E12;
         for (int k = 0; k < 3; k++) base_in[k] = vtx[3 + k];
         dir_a_in  = e12;
         num_a_in  = NW'(d4) - NW'(d3);
         den_in    = NW'(d4) - NW'(d3) + NW'(d5) - NW'(d6);
      end else begin
         region_in = REG_INT;
         dir_a_in  = e01;
         dir_b_in  = e02;
         num_a_in  = NW'(vb);
         num_b_in  = NW'(vc);
         den_in    = NW'(va) + NW'(vb) + NW'(vc);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff   <= base_in;
         dir_a_ff  <= dir_a_in;
         dir_b_ff  <= dir_b_in;
         region_ff <= region_in;
         num_a_ff  <= num_a_in;
         num_b_ff  <= num_b_in;
         den_ff    <= den_in;
      end
   end

   assign base   = base_ff;
   assign dir_a  = dir_a_ff;
   assign dir_b  = dir_b_ff;
   assign region = region_ff;
   assign num_a  = num_a_ff;
   assign num_b  = num_b_ff;
   assign den    = den_ff;

endmodule

// ----- rtl/stoc_div.sv -----
// Two-lane pipelined restoring divider with shared divisor: one quotient bit
// per stage, weight clamped to 0..1.0. Carries a side tag. No dependencies.
module stoc_div #(
   parameter int NW    = 77,
   parameter int WF    = 16,
   parameter int TAG_W = 105
) (
   input  logic                clock,
   input  logic [WF:0]         en,
   input  logic signed [NW-1:0] num_a,
   input  logic signed [NW-1:0] num_b,
   input  logic signed [NW-1:0] den,
   input  logic [TAG_W-1:0]    tag_in,
   output logic [WF:0]         w_a,
   output logic [WF:0]         w_b,
   output logic                deg,
   output logic [TAG_W-1:0]    tag_out
);

   localparam logic [WF:0] ONE = {1'b1, {WF{1'b0}}};

   logic [NW-2:0]    rem_ff [WF+1][2];
   logic [NW-2:0]    rem_in [WF+1][2];
   logic [WF:0]      q_ff   [WF+1][2];
   logic [WF:0]      q_in   [WF+1][2];
   logic             run_ff [WF+1][2];
   logic             run_in [WF+1][2];
   logic [NW-2:0]    den_ff [WF+1];
   logic             deg_ff [WF+1];
   logic [TAG_W-1:0] tag_ff [WF+1];
   logic signed [NW-1:0] num [2];

   assign num[0] = num_a;
   assign num[1] = num_b;

   always_comb begin
      logic [NW-1:0] sh;
      logic [NW-1:0] diff;
      for (int l = 0; l < 2; l++) begin
         run_in[0][l] = 1'b0;
         rem_in[0][l] = '0;
         q_in[0][l]   = '0;
         if (den > 0 && num[l] > 0) begin
            if (num[l] >= den) begin
               q_in[0][l] = ONE;
            end else begin
               run_in[0][l] = 1'b1;
               rem_in[0][l] = num[l][NW-2:0];
            end
         end
         for (int s = 1; s <= WF; s++) begin
            sh   = {rem_ff[s-1][l], 1'b0};
            diff = sh - {1'b0, den_ff[s-1]};
            run_in[s][l] = run_ff[s-1][l];
            rem_in[s][l] = rem_ff[s-1][l];
            q_in[s][l]   = q_ff[s-1][l];
            if (run_ff[s-1][l]) begin
               if (sh >= {1'b0, den_ff[s-1]}) begin
                  rem_in[s][l] = diff[NW-2:0];
                  q_in[s][l]   = {q_ff[s-1][l][WF-1:0], 1'b1};
               end else begin
                  rem_in[s][l] = sh[NW-2:0];
                  q_in[s][l]   = {q_ff[s-1][l][WF-1:0], 1'b0};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         run_ff[0] <= run_in[0];
         den_ff[0] <= den[NW-2:0];
         deg_ff[0] <= !(den > 0);
         tag_ff[0] <= tag_in;
      end
      for (int s = 1; s <= WF; s++) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            run_ff[s] <= run_in[s];
            den_ff[s] <= den_ff[s-1];
            deg_ff[s] <= deg_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign w_a     = q_ff[WF][0];
   assign w_b     = q_ff[WF][1];
   assign deg     = deg_ff[WF];
   assign tag_out = tag_ff[WF];

endmodule

// ----- rtl/stoc_tail.sv -----
// Tail pipeline: weighted blend, floor shift to the closest point, squared
// distance and hit compare; holds the result register. Uses stoc_pkg.
module stoc_tail import stoc_pkg::*; #(
   parameter  int CW = COORD_WIDTH_DEF,
   parameter  int WF = WEIGHT_FRAC_DEF,
   localparam int DW = CW + 1
) (
   input  logic                   clock,
   input  logic [TAIL_STAGES-1:0] en,
   input  logic signed [CW-1:0]   base [3],
   input  logic signed [DW-1:0]   dir_a [3],
   input  logic signed [DW-1:0]   dir_b [3],
   input  logic [WF:0]            w_a,
   input  logic [WF:0]            w_b,
   input  region_type             region,
   input  logic                   deg,
   input  logic signed [CW-1:0]   ctr [3],
   input  logic [CW-2:0]          radius,
   output logic                   hit,
   output logic signed [CW-1:0]   closest [3],
   output region_type             region_out,
   output logic                   deg_out
);

   localparam int PRW = DW + WF + 2;
   localparam int TW  = CW + WF + 4;
   localparam int QW  = TW - WF;
   localparam int DQW = QW + 1;
   localparam int SQW = 2 * DQW;
   localparam int RSW = 2 * (CW - 1);

   logic signed [PRW-1:0] pa_ff [3];
   logic signed [PRW-1:0] pb_ff [3];
   logic signed [CW-1:0]  base_ff [3];
   logic signed [QW-1:0]  q_ff [3];
   logic [SQW-1:0]        sq_ff [3];
   logic signed [CW-1:0]  cl_ff [3];
   logic signed [CW-1:0]  out_ff [3];
   region_type            region_ff [TAIL_STAGES];
   logic                  deg_ff [TAIL_STAGES];
   logic [RSW-1:0]        rsq_ff;
   logic                  hit_ff;
   logic signed [PRW-1:0] pa_in [3];
   logic signed [PRW-1:0] pb_in [3];
   logic signed [QW-1:0]  q_in [3];
   logic [SQW-1:0]        sq_in [3];
   logic [SQW+1:0]        dist_sum;

   always_comb begin
      logic signed [WF+1:0] wa_s;
      logic signed [WF+1:0] wb_s;
      logic signed [TW-1:0] t;
      logic signed [DQW-1:0] dv;
      wa_s = {1'b0, w_a};
      wb_s = {1'b0, w_b};
      dist_sum = '0;
      for (int k = 0; k < 3; k++) begin
         pa_in[k] = dir_a[k] * wa_s;
         pb_in[k] = dir_b[k] * wb_s;
         t        = (TW'(base_ff[k]) <<< WF) + TW'(pa_ff[k]) + TW'(pb_ff[k]);
         q_in[k]  = t[TW-1:WF];
         dv       = DQW'(q_ff[k]) - DQW'(ctr[k]);
         sq_in[k] = SQW'(dv * dv);
         dist_sum = dist_sum + (SQW+2)'(sq_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      rsq_ff <= RSW'(radius) * RSW'(radius);
      if (en[0]) begin
         pa_ff        <= pa_in;
         pb_ff        <= pb_in;
         base_ff      <= base;
         region_ff[0] <= region;
         deg_ff[0]    <= deg;
      end
      if (en[1]) begin
         q_ff         <= q_in;
         region_ff[1] <= region_ff[0];
         deg_ff[1]    <= deg_ff[0];
      end
      if (en[2]) begin
         sq_ff        <= sq_in;
         for (int k = 0; k < 3; k++) cl_ff[k] <= q_ff[k][CW-1:0];
         region_ff[2] <= region_ff[1];
         deg_ff[2]    <= deg_ff[1];
      end
      if (en[3]) begin
         hit_ff       <= (dist_sum <= (SQW+2)'(rsq_ff));
         out_ff       <= cl_ff;
         region_ff[3] <= region_ff[2];
         deg_ff[3]    <= deg_ff[2];
      end
   end

   assign hit        = hit_ff;
   assign closest    = out_ff;
   assign region_out = region_ff[TAIL_STAGES-1];
   assign deg_out    = deg_ff[TAIL_STAGES-1];

endmodule

// ----- rtl/sphere_triangle_overlap_test_core.sv -----
// Sphere/triangle overlap core: top level with config registers and the
// pipeline valid/stall chain. Uses stoc_pkg, stoc_front, stoc_sel, stoc_div, stoc_tail.

// Takes one triangle per cycle unless output backpressure stalls the pipeline,
// and returns one beat per triangle, in order: the closest point of the
// triangle to the sphere center (Q8.8, floor), its Voronoi region, a hit
// flag (squared distance at most radius squared) and a degenerate flag
// (zero or negative weight divisor). The weight divider, one quotient bit
// per stage, makes up most of the pipeline. Each stage advances when its
// successor can take data, so bubbles close up under output backpressure.
// Write the sphere registers only while no beat is in flight.
`include "sphere_triangle_overlap_test_core_macros.svh"

module sphere_triangle_overlap_test_core import stoc_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_v0_x,
   input  logic signed [COORD_WIDTH-1:0] req_v0_y,
   input  logic signed [COORD_WIDTH-1:0] req_v0_z,
   input  logic signed [COORD_WIDTH-1:0] req_v1_x,
   input  logic signed [COORD_WIDTH-1:0] req_v1_y,
   input  logic signed [COORD_WIDTH-1:0] req_v1_z,
   input  logic signed [COORD_WIDTH-1:0] req_v2_x,
   input  logic signed [COORD_WIDTH-1:0] req_v2_y,
   input  logic signed [COORD_WIDTH-1:0] req_v2_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic signed [COORD_WIDTH-1:0] rsp_closest_x,
   output logic signed [COORD_WIDTH-1:0] rsp_closest_y,
   output logic signed [COORD_WIDTH-1:0] rsp_closest_z,
   output logic [2:0]                 rsp_region,
   output logic                       rsp_degenerate
);

   localparam int CW      = COORD_WIDTH;
   localparam int WF      = WEIGHT_FRAC_BITS;
   localparam int DW      = CW + 1;
   localparam int DOTW    = 2 * DW + 2;
   localparam int VW      = 2 * DOTW + 1;
   localparam int NW      = VW + 2;
   localparam int SEL_AT  = FRONT_STAGES;
   localparam int DIV_AT  = SEL_AT + SEL_STAGES;
   localparam int TAIL_AT = DIV_AT + WF + 1;
   localparam int NSTG    = TAIL_AT + TAIL_STAGES;
   localparam int TAG_W   = 3 + 3 * CW + 6 * DW;

   logic signed [CW-1:0] ctr_ff [3];
   logic [CW-2:0]        radius_ff;
   logic [NSTG-1:0]      valid_ff;
   logic [NSTG-1:0]      valid_in;
   logic [NSTG-1:0]      en;

   logic signed [CW-1:0]   vtx [9];
   logic signed [CW-1:0]   f_vtx [9];
   logic signed [DOTW-1:0] f_dot [6];
   logic signed [VW-1:0]   f_va, f_vb, f_vc;
   logic signed [CW-1:0]   s_base [3];
   logic signed [DW-1:0]   s_dir_a [3];
   logic signed [DW-1:0]   s_dir_b [3];
   region_type             s_region;
   logic signed [NW-1:0]   s_num_a, s_num_b, s_den;
   logic [TAG_W-1:0]       tag_in, tag_out;
   logic [WF:0]            w_a, w_b;
   logic                   d_deg;
   logic [2:0]             t_region;
   logic signed [CW-1:0]   t_base [3];
   logic signed [DW-1:0]   t_dir_a [3];
   logic signed [DW-1:0]   t_dir_b [3];
   logic signed [CW-1:0]   closest [3];
   region_type             region_out;

   assign vtx = '{req_v0_x, req_v0_y, req_v0_z, req_v1_x, req_v1_y, req_v1_z,
                  req_v2_x, req_v2_y, req_v2_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff    <= '{default: '0};
         radius_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_CENTER_X: ctr_ff[0] <= csr_write_data;
            CSR_CENTER_Y: ctr_ff[1] <= csr_write_data;
            CSR_CENTER_Z: ctr_ff[2] <= csr_write_data;
            CSR_RADIUS:   radius_ff <= csr_write_data[CW-2:0];
            default:      radius_ff <= radius_ff;
         endcase
      end
   end

   // stall chain: a stage moves when empty or when its successor moves
   always_comb begin
      en[NSTG-1] = rsp_ready || !valid_ff[NSTG-1];
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign valid_in = {valid_ff[NSTG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NSTG-1];

   stoc_front #(.CW(CW)) u_front (
      .clock   (clock),
      .en      (en[FRONT_STAGES-1:0]),
      .vtx     (vtx),
      .ctr     (ctr_ff),
      .vtx_out (f_vtx),
      .dot_out (f_dot),
      .va      (f_va),
      .vb      (f_vb),
      .vc      (f_vc)
   );

   stoc_sel #(.CW(CW)) u_sel (
      .clock  (clock),
      .en     (en[SEL_AT]),
      .vtx    (f_vtx),
      .dot    (f_dot),
      .va     (f_va),
      .vb     (f_vb),
      .vc     (f_vc),
      .base   (s_base),
      .dir_a  (s_dir_a),
      .dir_b  (s_dir_b),
      .region (s_region),
      .num_a  (s_num_a),
      .num_b  (s_num_b),
      .den    (s_den)
   );

   assign tag_in = {s_region, s_base[0], s_base[1], s_base[2],
                    s_dir_a[0], s_dir_a[1], s_dir_a[2],
                    s_dir_b[0], s_dir_b[1], s_dir_b[2]};

   stoc_div #(.NW(NW), .WF(WF), .TAG_W(TAG_W)) u_div (
      .clock   (clock),
      .en      (en[DIV_AT +: WF+1]),
      .num_a   (s_num_a),
      .num_b   (s_num_b),
      .den     (s_den),
      .tag_in  (tag_in),
      .w_a     (w_a),
      .w_b     (w_b),
      .deg     (d_deg),
      .tag_out (tag_out)
   );

   always_comb begin
      {t_region, t_base[0], t_base[1], t_base[2],
       t_dir_a[0], t_dir_a[1], t_dir_a[2],
       t_dir_b[0], t_dir_b[1], t_dir_b[2]} = tag_out;
   end

   stoc_tail #(.CW(CW), .WF(WF)) u_tail (
      .clock      (clock),
      .en         (en[TAIL_AT +: TAIL_STAGES]),
      .base       (t_base),
      .dir_a      (t_dir_a),
      .dir_b      (t_dir_b),
      .w_a        (w_a),
      .w_b        (w_b),
      .region     (region_type'(t_region)),
      .deg        (d_deg),
      .ctr        (ctr_ff),
      .radius     (radius_ff),
      .hit        (rsp_hit),
      .closest    (closest),
      .region_out (region_out),
      .deg_out    (rsp_degenerate)
   );

   assign rsp_closest_x = closest[0];
   assign rsp_closest_y = closest[1];
   assign rsp_closest_z = closest[2];
   assign rsp_region    = region_out;

   `STOC_ASSERT_NEXT(a_load_first, clock, reset, req_valid && req_ready, valid_ff[0], "accepted beat did not enter first stage")
   `STOC_ASSERT_NOW(a_stall_full, clock, reset, !req_ready, &valid_ff, "input stalled while pipeline holds a bubble")
   `STOC_ASSERT_NOW(a_deg_region, clock, reset, rsp_valid && rsp_degenerate, (rsp_region == REG_E01 || rsp_region == REG_E02 || rsp_region == REG_E12 || rsp_region == REG_INT), "degenerate flag on a vertex region")

endmodule
